// ===== rtl/csgb_pkg.sv =====
// ----------------------------------------------------------------------------
// csgb_pkg
// Shared types and constants of the five-point stencil blur block: payload
// structs, function and result codes, register indexes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package csgb_pkg;

  // Function codes of an input item
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Configuration register indexes and widths
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PASS_COUNT   = 2'd2;

  localparam logic [6:0] ROW_COUNT_RST    = 7'd64;
  localparam logic [6:0] COLUMN_COUNT_RST = 7'd64;
  localparam logic [7:0] PASS_COUNT_RST   = 8'd1;

  // Stencil tap selects
  localparam logic [2:0] TAP_CENTRE = 3'd0;
  localparam logic [2:0] TAP_NORTH  = 3'd1;
  localparam logic [2:0] TAP_SOUTH  = 3'd2;
  localparam logic [2:0] TAP_WEST   = 3'd3;
  localparam logic [2:0] TAP_EAST   = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               result_kind;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       item_wr;
    logic       item_rd;
    logic       copy_start;
    logic       copy_rd;
    logic       sweep_start;
    logic       sweep_step;
    logic       snap_rd;
    logic [2:0] tap;
    logic       acc_clr;
    logic       div_start;
    logic       grid_wb;
    logic       out_load;
    logic       out_kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_interior;
    logic copy_last;
    logic col_last;
    logic row_last;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/csgb_div5.sv =====
// ----------------------------------------------------------------------------
// csgb_div5
// Signed divide by five, truncated toward zero. Multiplies the magnitude by a
// scaled reciprocal of five, then restores the sign. Busy for one cycle after
// start; the quotient is registered at the end of that cycle.
// ----------------------------------------------------------------------------
module csgb_div5 import csgb_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS+2:0] dividend,
  output logic                          busy,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  localparam int ACW = SAMPLE_BITS + 3;
  localparam int MW  = SAMPLE_BITS + 2;
  // Three spare shift bits keep the reciprocal exact over the whole magnitude
  localparam int SH  = MW + 3;
  localparam int RCW = SH - 2;
  localparam int PRW = MW + RCW;
  localparam logic [RCW-1:0] RECIP = RCW'(((64'd1 << SH) + 64'd4) / 64'd5);

  logic                   busy_r;
  logic                   neg_r;
  logic [MW-1:0]          mag_r;
  logic [SAMPLE_BITS-1:0] q_r;
  logic [ACW-1:0]         mag;
  logic [PRW-1:0]         prod;
  logic [SAMPLE_BITS-1:0] q_mag;

  // Magnitude of the dividend
  assign mag = dividend[ACW-1] ? (~dividend + 1'b1) : dividend;

  // Scale by the reciprocal and keep the integer part
  assign prod  = PRW'(mag_r) * PRW'(RECIP);
  assign q_mag = prod[SH +: SAMPLE_BITS];

  // Control: one busy cycle per start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  // Payload: capture the magnitude, then register the signed quotient
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[ACW-1];
      mag_r <= mag[MW-1:0];
    end
    if (busy_r) begin
      q_r <= neg_r ? (~q_mag + 1'b1) : q_mag;
    end
  end

  assign quotient = $signed(q_r);
  assign busy     = busy_r;

endmodule

// ===== rtl/csgb_dp.sv =====
// ----------------------------------------------------------------------------
// csgb_dp
// Datapath: grid and snapshot memories, copy and sweep counters, stencil
// accumulator, divider and the result register.
// ----------------------------------------------------------------------------
module csgb_dp import csgb_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [5:0]         in_row,
  input  logic [5:0]         in_col,
  input  logic signed [15:0] in_sample,
  input  logic [6:0]         row_count,
  input  logic [6:0]         column_count,
  input  logic               out_ready,
  output logic               out_valid,
  output out_item_t          out_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int ACW   = SAMPLE_BITS + 3;

  logic [SAMPLE_BITS-1:0] grid_mem [CELLS];
  logic [SAMPLE_BITS-1:0] snap_mem [CELLS];

  logic [RNW-1:0] nr;
  logic [CNW-1:0] nc;
  logic           in_range;
  logic [AW-1:0]  item_addr;
  logic [AW-1:0]  k_addr;
  logic [AW-1:0]  tap_addr;

  logic [AW-1:0]  copy_addr_r;
  logic [AW-1:0]  copy_waddr_r;
  logic           copy_wr_r;
  logic [RW-1:0]  r_r;
  logic [CW-1:0]  c_r;
  logic           rd_vld_r;
  logic           rd_zero_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [SAMPLE_BITS-1:0] grid_q_r;
  logic signed [SAMPLE_BITS-1:0] snap_q_r;
  logic           out_valid_r;
  out_item_t      out_data_r;

  logic                   grid_we;
  logic [AW-1:0]          grid_waddr;
  logic [SAMPLE_BITS-1:0] grid_wdata;
  logic                   grid_re;
  logic [AW-1:0]          grid_raddr;
  logic signed [SAMPLE_BITS-1:0] div_q;
  logic                   div_busy;

  // Clamp the configured size to the memory size
  assign nr = (32'(row_count) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(row_count);
  assign nc = (32'(column_count) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(column_count);

  assign in_range  = (in_row < nr) && (in_col < nc);
  assign item_addr = AW'(int'(in_row) * MAX_COLS + int'(in_col));
  assign k_addr    = AW'(int'(r_r) * MAX_COLS + int'(c_r));

  // Select the stencil tap address
  always_comb begin
    case (cmd.tap)
      TAP_CENTRE: tap_addr = k_addr;
      TAP_NORTH:  tap_addr = k_addr - AW'(MAX_COLS);
      TAP_SOUTH:  tap_addr = k_addr + AW'(MAX_COLS);
      TAP_WEST:   tap_addr = k_addr - AW'(1);
      TAP_EAST:   tap_addr = k_addr + AW'(1);
      default:    tap_addr = k_addr;
    endcase
  end

  // Grid port muxing
  assign grid_we    = (cmd.item_wr && in_range) || cmd.grid_wb;
  assign grid_waddr = cmd.grid_wb ? k_addr : item_addr;
  assign grid_wdata = cmd.grid_wb ? div_q : SAMPLE_BITS'($unsigned(in_sample));
  assign grid_re    = cmd.item_rd || cmd.copy_rd;
  assign grid_raddr = cmd.copy_rd ? copy_addr_r : item_addr;

  // Grid memory
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    if (grid_re) begin
      grid_q_r <= grid_mem[grid_raddr];
    end
  end

  // Snapshot memory, filled in the cycle after the grid read
  always_ff @(posedge clk) begin
    if (copy_wr_r) begin
      snap_mem[copy_waddr_r] <= grid_q_r;
    end
    if (cmd.snap_rd) begin
      snap_q_r <= snap_mem[tap_addr];
    end
  end

  // Control registers: copy strobe, tap data valid, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_wr_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      copy_wr_r <= cmd.copy_rd;
      rd_vld_r  <= cmd.snap_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Counters, accumulator and result payload
  always_ff @(posedge clk) begin
    if (cmd.copy_start) begin
      copy_addr_r <= '0;
    end else if (cmd.copy_rd) begin
      copy_addr_r <= copy_addr_r + 1'b1;
    end
    if (cmd.copy_rd) begin
      copy_waddr_r <= copy_addr_r;
    end
    if (cmd.sweep_start) begin
      r_r <= RW'(1);
      c_r <= CW'(1);
    end else if (cmd.sweep_step) begin
      if (sts.col_last) begin
        c_r <= CW'(1);
        r_r <= r_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + ACW'(snap_q_r);
    end
    if (cmd.item_rd) begin
      rd_zero_r <= !in_range;
    end
    if (cmd.out_load) begin
      out_data_r.result_kind <= cmd.out_kind;
      if (cmd.out_kind == KIND_RUN || rd_zero_r) begin
        out_data_r.sample_out <= '0;
      end else begin
        out_data_r.sample_out <= 16'(grid_q_r);
      end
    end
  end

  csgb_div5 #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div5 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Status back to the controller
  assign sts.has_interior = (nr >= RNW'(3)) && (nc >= CNW'(3));
  assign sts.copy_last    = (copy_addr_r == AW'(CELLS - 1));
  assign sts.col_last     = ((CNW'(c_r) + CNW'(2)) == nc);
  assign sts.row_last     = ((RNW'(r_r) + RNW'(2)) == nr);
  assign sts.div_busy     = div_busy;
  assign sts.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/csgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csgb_ctrl
// Controller: takes items, sequences the per-pass snapshot copy and the
// interior sweep (five tap reads, divide, write back) and issues results.
// ----------------------------------------------------------------------------
module csgb_ctrl import csgb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_ready,
  input  logic [7:0] pass_count,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_READ   = 9'b000000010,
    S_COPY   = 9'b000000100,
    S_TAP    = 9'b000001000,
    S_SUM    = 9'b000010000,
    S_DSTART = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_WB     = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] pass_r, pass_nxt;
  logic [2:0] tap_r, tap_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_WRITE: cmd.item_wr = 1'b1;
            FUNC_READ: begin
              cmd.item_rd = 1'b1;
              state_nxt   = S_READ;
            end
            FUNC_RUN: begin
              if (pass_count == '0 || !sts.has_interior) begin
                state_nxt = S_DONE;
              end else begin
                pass_nxt       = pass_count;
                cmd.copy_start = 1'b1;
                state_nxt      = S_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_READ;
          state_nxt    = S_IDLE;
        end
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        if (sts.copy_last) begin
          cmd.sweep_start = 1'b1;
          tap_nxt         = TAP_CENTRE;
          state_nxt       = S_TAP;
        end
      end
      S_TAP: begin
        cmd.snap_rd = 1'b1;
        cmd.tap     = tap_r;
        cmd.acc_clr = (tap_r == TAP_CENTRE);
        tap_nxt     = tap_r + 1'b1;
        if (tap_r == TAP_EAST) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: state_nxt = S_DSTART;
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.grid_wb    = 1'b1;
        cmd.sweep_step = 1'b1;
        tap_nxt        = TAP_CENTRE;
        if (sts.col_last && sts.row_last) begin
          pass_nxt = pass_r - 1'b1;
          if (pass_r == 8'd1) begin
            state_nxt = S_DONE;
          end else begin
            cmd.copy_start = 1'b1;
            state_nxt      = S_COPY;
          end
        end else begin
          state_nxt = S_TAP;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_RUN;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= '0;
      tap_r   <= TAP_CENTRE;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      tap_r   <= tap_nxt;
    end
  end

endmodule

// ===== rtl/cross_stencil_grid_blur.sv =====
// ----------------------------------------------------------------------------
// cross_stencil_grid_blur
// Grid of signed samples with load, read and repeated five-point average
// blur. Holds the configuration registers and joins controller and datapath.
// ----------------------------------------------------------------------------
//  channel | ports                          | transfer
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | in_valid & in_ready
//  out     | out_valid, out_ready, out_data | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_data    | cfg_we, no wait, no read-back
//
//  A write is taken in the idle state; a read loads its result once the result
//  register is free. A run makes, per pass, a snapshot copy of MAX_ROWS*MAX_COLS
//  cells through the single grid read port, then for each interior cell five
//  snapshot reads, a sum step, divider start, the divide and the write back.
//  in_ready is high only while the controller is idle; a pending result does
//  not hold back the next item. Reset is synchronous and needs no memory clear.
// ----------------------------------------------------------------------------
module cross_stencil_grid_blur import csgb_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [6:0] row_count_r;
  logic [6:0] column_count_r;
  logic [7:0] pass_count_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
      pass_count_r   <= PASS_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_data[6:0];
        CFG_COLUMN_COUNT: column_count_r <= cfg_data[6:0];
        CFG_PASS_COUNT:   pass_count_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  csgb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_func    (in_data.func),
    .in_ready   (in_ready),
    .pass_count (pass_count_r),
    .sts        (sts),
    .cmd        (cmd)
  );

  csgb_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_row       (in_data.row),
    .in_col       (in_data.col),
    .in_sample    (in_data.sample_in),
    .row_count    (row_count_r),
    .column_count (column_count_r),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

// ===== rtl/csgb_chk.sv =====
// ----------------------------------------------------------------------------
// csgb_chk
// Port-level checks of the blur block, bound to the top level.
// ----------------------------------------------------------------------------
module csgb_chk import csgb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Drop any result on reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Report run completion with a zero sample
  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_RUN |-> out_data.sample_out == '0)
    else $error("run completion carries a non-zero sample");

  // Deliver a read result, loaded in the S_READ state, after its transfer into an empty output
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_READ && !out_valid
    |-> ##2 (out_valid && out_data.result_kind == KIND_READ))
    else $error("read result missing");

endmodule

bind cross_stencil_grid_blur csgb_chk u_chk (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the five-point stencil blur grid. Loads, reads and
// blur runs go through the valid/ready input channel. A mirror of the grid
// predicts every read value and run completion, and each result is compared
// in order. Layouts change between phases, only while the block is quiet.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csgb_pkg::*;

  localparam int GRID_ROWS     = 64;
  localparam int GRID_COLS     = 64;
  localparam int MAX_GAP       = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  // Longest legal silence is one run of 255 passes, each a full snapshot copy
  localparam int STALL_LIMIT   = 3_500_000;

  localparam logic [1:0]              FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE   = 2'd3;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  out_item_t                out_data;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  // Mirror of the grid and of the configuration registers
  logic signed [15:0] grid_mirror [GRID_ROWS*GRID_COLS];
  logic [6:0]         rows_cfg   = ROW_COUNT_RST;
  logic [6:0]         cols_cfg   = COLUMN_COUNT_RST;
  logic [7:0]         passes_cfg = PASS_COUNT_RST;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  bit burst_mode   = 1'b0;
  bit in_busy      = 1'b0;
  bit in_fired     = 1'b0;
  int in_gap       = 0;
  int out_stall    = 0;
  int quiet_cycles = 0;
  int fail_count   = 0;

  always #5ns clk = ~clk;

  cross_stencil_grid_blur dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clamp a size register to the grid dimension
  function automatic int used_extent(logic [6:0] v, int limit);
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  // One pass: every interior sample becomes the truncated mean of its cross
  function automatic void blur_grid(int nr, int nc);
    logic signed [15:0] snap [GRID_ROWS*GRID_COLS];
    int k;
    int acc;
    if (nr < 3 || nc < 3) return;
    snap = grid_mirror;
    for (int r = 1; r + 1 < nr; r++) begin
      for (int c = 1; c + 1 < nc; c++) begin
        k   = r * GRID_COLS + c;
        acc = int'(snap[k]) + int'(snap[k - GRID_COLS]) + int'(snap[k + GRID_COLS])
            + int'(snap[k - 1]) + int'(snap[k + 1]);
        grid_mirror[k] = 16'(acc / 5);
      end
    end
  endfunction

  // Apply one transferred item to the mirror and queue what it must return
  function automatic void predict_item(in_item_t it);
    int        nr;
    int        nc;
    int        k;
    bit        in_range;
    out_item_t res;
    nr       = used_extent(rows_cfg, GRID_ROWS);
    nc       = used_extent(cols_cfg, GRID_COLS);
    in_range = (int'(it.row) < nr) && (int'(it.col) < nc);
    k        = int'(it.row) * GRID_COLS + int'(it.col);
    case (it.func)
      FUNC_WRITE: begin
        if (in_range) grid_mirror[k] = it.sample_in;
      end
      FUNC_RUN: begin
        repeat (passes_cfg) blur_grid(nr, nc);
        res.sample_out  = '0;
        res.result_kind = KIND_RUN;
        expected_results.push_back(res);
      end
      FUNC_READ: begin
        res.sample_out  = in_range ? grid_mirror[k] : '0;
        res.result_kind = KIND_READ;
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("MISMATCH %0t: %s", $realtime, msg);
  endfunction

  // Check results, mirror transferred items and watch for a hang
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        out_stall    = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result sample_out=%0d kind=%0d",
                                    out_data.sample_out, out_data.result_kind));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (want.sample_out !== out_data.sample_out ||
              want.result_kind !== out_data.result_kind)
            report_mismatch($sformatf(
              "expected sample_out=%0d kind=%0d, got sample_out=%0d kind=%0d",
              want.sample_out, want.result_kind, out_data.sample_out,
              out_data.result_kind));
        end
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        in_fired     = 1'b1;
        predict_item(in_data);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("cross_stencil_grid_blur: mismatch");
        $finish;
      end
    end
  end

  // Drive the input channel from the pending queue, hold until transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fired) begin
        in_fired = 1'b0;
        in_busy  = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items[0];
          pending_items.delete(0);
          in_busy = 1'b1;
          in_gap  = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      in_valid <= in_busy;
    end
  end

  // Stall the result channel for the drawn number of cycles after each transfer
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic post_item(logic [1:0] func, int r, int c, logic [15:0] s);
    in_item_t it;
    it.func      = func;
    it.row       = 6'(r);
    it.col       = 6'(c);
    it.sample_in = s;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Choose a location inside the layout, or outside it where possible
  task automatic pick_location(bit want_inside, int nr, int nc, output int r, output int c);
    if (want_inside && nr > 0 && nc > 0) begin
      r = $urandom_range(0, nr - 1);
      c = $urandom_range(0, nc - 1);
    end else begin
      r = $urandom_range(0, GRID_ROWS - 1);
      c = $urandom_range(0, GRID_COLS - 1);
      if (r < nr && c < nc) begin
        if (nr < GRID_ROWS) r = $urandom_range(nr, GRID_ROWS - 1);
        else if (nc < GRID_COLS) c = $urandom_range(nc, GRID_COLS - 1);
      end
    end
  endtask

  // Wait until every item is taken and every result is back, then settle
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ROW_COUNT:    rows_cfg   = val[6:0];
      CFG_COLUMN_COUNT: cols_cfg   = val[6:0];
      CFG_PASS_COUNT:   passes_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reprogram all registers; the unused top bit of the size values is random
  task automatic set_layout(logic [6:0] rows, logic [6:0] cols, logic [7:0] passes);
    wait_quiet();
    cfg_write(CFG_ROW_COUNT, {1'($urandom_range(0, 1)), rows});
    cfg_write(CFG_COLUMN_COUNT, {1'($urandom_range(0, 1)), cols});
    cfg_write(CFG_PASS_COUNT, passes);
    cfg_write(CFG_SPARE, 8'($urandom));
    @(posedge clk);
  endtask

  // Load the whole layout, then mix loads, reads, runs and stray accesses
  task automatic run_phase(logic [6:0] rows, logic [6:0] cols, logic [7:0] passes,
                           int items, bit burst);
    int nr;
    int nc;
    int r;
    int c;
    int pick;
    int done;
    set_layout(rows, cols, passes);
    burst_mode = burst;
    nr = used_extent(rows_cfg, GRID_ROWS);
    nc = used_extent(cols_cfg, GRID_COLS);
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++) post_item(FUNC_WRITE, i, j, pick_sample());
    // Long pass counts get a single run only
    if (passes > 8'd3) post_item(FUNC_RUN, $urandom, $urandom, 16'($urandom));
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        post_item(FUNC_UNUSED, $urandom, $urandom, 16'($urandom));
      end else begin
        done++;
        if (pick < 40) begin
          pick_location(1'b1, nr, nc, r, c);
          post_item(FUNC_WRITE, r, c, pick_sample());
        end else if (pick < 48) begin
          pick_location(1'b0, nr, nc, r, c);
          post_item(FUNC_WRITE, r, c, pick_sample());
        end else if (pick < 84 || (pick >= 95 && passes > 8'd3)) begin
          pick_location(1'b1, nr, nc, r, c);
          post_item(FUNC_READ, r, c, 16'($urandom));
        end else if (pick < 95) begin
          pick_location(1'b0, nr, nc, r, c);
          post_item(FUNC_READ, r, c, 16'($urandom));
        end else begin
          post_item(FUNC_RUN, $urandom, $urandom, 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset layout: corners of the full grid, extreme samples, stray code
    post_item(FUNC_WRITE, 0, 0, 16'h8000);
    post_item(FUNC_WRITE, 63, 63, 16'h7FFF);
    post_item(FUNC_WRITE, 0, 63, 16'hFFFF);
    post_item(FUNC_WRITE, 63, 0, 16'h5555);
    post_item(FUNC_UNUSED, 0, 0, 16'h1234);
    post_item(FUNC_READ, 0, 0, 16'h0000);
    post_item(FUNC_READ, 63, 63, 16'hFFFF);
    post_item(FUNC_READ, 0, 63, 16'h0000);
    post_item(FUNC_READ, 63, 0, 16'h0000);

    // Smallest grid with an interior: negative centre, zero passes first
    set_layout(7'd3, 7'd3, 8'd0);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        post_item(FUNC_WRITE, i, j, (i == 1 && j == 1) ? 16'hFFF9 : 16'h0000);
    post_item(FUNC_WRITE, 3, 0, 16'h1111);
    post_item(FUNC_RUN, 0, 0, 16'h0000);
    post_item(FUNC_READ, 1, 1, 16'h0000);
    post_item(FUNC_READ, 0, 63, 16'h0000);

    // One pass: the mean must round toward zero
    wait_quiet();
    cfg_write(CFG_PASS_COUNT, 8'd1);
    @(posedge clk);
    post_item(FUNC_RUN, 0, 0, 16'h0000);
    post_item(FUNC_READ, 1, 1, 16'h0000);

    // Layouts: regular, empty rows, clamped rows, wide, tiny, no interior,
    // maximum pass count, empty columns with zero passes, then random ones
    run_phase(7'd5, 7'd5, 8'd1, 50, 1'b0);
    run_phase(7'd0, 7'd9, 8'd2, 50, 1'b0);
    run_phase(7'd127, 7'd3, 8'd1, 50, 1'b0);
    run_phase(7'd3, 7'd64, 8'd2, 50, 1'b1);
    run_phase(7'd1, 7'd1, 8'd3, 50, 1'b0);
    run_phase(7'd2, 7'd17, 8'd1, 50, 1'b0);
    run_phase(7'd3, 7'd3, 8'd255, 40, 1'b0);
    run_phase(7'd7, 7'd0, 8'd0, 50, 1'b0);
    for (int p = 0; p < 8; p++)
      run_phase(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)),
                8'($urandom_range(0, 3)), 50, p % 4 == 3);

    wait_quiet();
    if (fail_count == 0) begin
      $display("cross_stencil_grid_blur: match");
    end else begin
      $display("cross_stencil_grid_blur: mismatch");
    end
    $finish;
  end

endmodule
